// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the tracker RTL.
// Each macro expands to one labeled concurrent assertion on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/hst_pkg.sv =====
// ----------------------------------------------------------------------------
// hst_pkg
// Types, constants and lookup tables of the Hall sector tracker.
// ----------------------------------------------------------------------------
package hst_pkg;

  // Thirty electrical degrees on a 16-bit turn.
  localparam logic [15:0] ANGLE_STEP = 16'd5461;
  // All six border bits set.
  localparam logic [5:0]  SEEN_ALL   = 6'b111111;
  localparam logic [2:0]  LAST_SECTOR = 3'd5;

  // Request from the tracker to the calibration unit for one beat.
  typedef struct packed {
    logic        step;
    logic        forward;
    logic [2:0]  sector;
    logic [15:0] raw;
  } calib_req_t;

  // Answer of the calibration unit for the same beat.
  typedef struct packed {
    logic        force_en;
    logic        done;
    logic [15:0] offset;
  } calib_rsp_t;

  // Sector of a Hall code; the invalid codes fall to sector zero.
  function automatic logic [2:0] sector_of(input logic [2:0] code);
    logic [2:0] s;
    unique case (code)
      3'd1:    s = 3'd4;
      3'd2:    s = 3'd2;
      3'd3:    s = 3'd3;
      3'd5:    s = 3'd5;
      3'd6:    s = 3'd1;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // Sector angle of a Hall code; the invalid codes give angle zero.
  function automatic logic [15:0] angle_of(input logic [2:0] code);
    logic [15:0] a;
    unique case (code)
      3'd1:    a = 16'd49152;
      3'd2:    a = 16'd27307;
      3'd3:    a = 16'd38229;
      3'd4:    a = 16'd5461;
      3'd5:    a = 16'd60075;
      3'd6:    a = 16'd16384;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  // Nominal encoder reading at each sector border.
  function automatic logic [15:0] nominal_of(input logic [2:0] idx);
    logic [15:0] n;
    unique case (idx)
      3'd1:    n = 16'd10923;
      3'd2:    n = 16'd21845;
      3'd3:    n = 16'd32768;
      3'd4:    n = 16'd43691;
      3'd5:    n = 16'd54613;
      default: n = 16'd0;
    endcase
    return n;
  endfunction

  // Following sector, modulo six.
  function automatic logic [2:0] next_sector(input logic [2:0] s);
    return (s >= LAST_SECTOR) ? 3'd0 : 3'(s + 3'd1);
  endfunction

endpackage

// ===== rtl/hst_if.sv =====
// ----------------------------------------------------------------------------
// hst_if
// Valid/ready channels for Hall events and tracker results.
// ----------------------------------------------------------------------------

// One Hall edge event per beat.
interface hst_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  hall_code;
  logic [15:0] encoder_raw;

  modport source (output valid, output hall_code, output encoder_raw, input ready);
  modport sink   (input valid, input hall_code, input encoder_raw, output ready);
endinterface

// One tracker result per beat.
interface hst_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_count;
  logic [15:0]        force_angle;
  logic               force_valid;
  logic               encoder_restart;
  logic               moved_forward;
  logic               calib_done;
  logic signed [15:0] calib_offset;
  logic [2:0]         hall_code_out;

  modport source (
    output valid, output position_count, output force_angle, output force_valid,
    output encoder_restart, output moved_forward, output calib_done,
    output calib_offset, output hall_code_out, input ready
  );
  modport sink (
    input valid, input position_count, input force_angle, input force_valid,
    input encoder_restart, input moved_forward, input calib_done,
    input calib_offset, input hall_code_out, output ready
  );
endinterface

// ===== rtl/hst_calib.sv =====
// ----------------------------------------------------------------------------
// hst_calib
// Encoder border calibration: tracks the phase, keeps one error per border
// and a running error sum, and gives the negated mean when all are known.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hst_calib
  import hst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  calib_req_t req,
  output calib_rsp_t rsp
);

  typedef enum logic [1:0] {
    PH_ARM  = 2'd0,
    PH_SCAN = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // Reset errors are those of all-zero samples; their sum is -32768.
  localparam logic signed [18:0] SUM_RESET = -19'sd32768;
  // Reciprocal of six, exact for magnitudes below 2**19.
  localparam logic [17:0]        RECIP_SIX = 18'd174763;
  localparam int                 RECIP_SHIFT = 20;

  phase_t             phase;
  logic [5:0]         seen;
  logic signed [15:0] border_err [6];
  logic signed [18:0] err_sum;

  logic [2:0]         bidx;
  logic signed [15:0] err_new;
  logic signed [15:0] err_old;
  logic signed [18:0] sum_next;
  logic [5:0]         seen_next;
  logic               scan_step;
  logic               done;
  logic [17:0]        mag;
  logic [35:0]        prod;
  logic [15:0]        quot;
  logic [15:0]        offset;

  // Border hit by this step and its error against the nominal reading.
  always_comb begin
    bidx      = req.forward ? req.sector : next_sector(req.sector);
    err_new   = signed'(req.raw - nominal_of(bidx));
    err_old   = border_err[bidx];
    sum_next  = err_sum - 19'(err_old) + 19'(err_new);
    seen_next = seen | (6'd1 << bidx);
    scan_step = req.step && (phase == PH_SCAN);
    done      = scan_step && (seen_next == SEEN_ALL);
  end

  // Mean of the six errors, truncated toward zero, then negated.
  always_comb begin
    mag  = sum_next[18] ? 18'(-sum_next) : sum_next[17:0];
    prod = mag * RECIP_SIX;
    quot = prod[RECIP_SHIFT +: 16];
    offset = sum_next[18] ? quot : 16'(-quot);
  end

  assign rsp.force_en = (phase == PH_ARM) || (phase == PH_SCAN);
  assign rsp.done     = done;
  assign rsp.offset   = done ? offset : 16'd0;

  // Phase, border errors and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_ARM;
      seen    <= '0;
      err_sum <= SUM_RESET;
      for (int i = 0; i < 6; i++) begin
        border_err[i] <= signed'(16'd0 - nominal_of(3'(i)));
      end
    end else if (req.step) begin
      unique case (phase)
        PH_ARM: begin
          phase <= PH_SCAN;
        end
        PH_SCAN: begin
          border_err[bidx] <= err_new;
          err_sum          <= sum_next;
          seen             <= seen_next;
          if (seen_next == SEEN_ALL) begin
            phase <= PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A finished calibration stays finished with every border recorded.
  `ASSERT_CLK(a_done_sticks, done |=> (phase == PH_DONE) && !rsp.force_en, "calibration did not finish")
  `ASSERT_ALWAYS(a_done_all_seen, (phase == PH_DONE) |-> (seen == SEEN_ALL), "done without all borders")

endmodule

// ===== rtl/hall_sector_tracker_with_encoder_calib.sv =====
// ----------------------------------------------------------------------------
// hall_sector_tracker_with_encoder_calib
// Stages: one input register and one result register, decode in between.
// Throughput: one Hall event per cycle while the result side does not stall;
//   the sector and count feedback closes in the single stage between the
//   two registers.
// Reset: synchronous; clears the count, previous code, calibration state and
//   both stage valids, so the first event afterwards takes the restart path.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hall_sector_tracker_with_encoder_calib
  import hst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hst_in_if.sink     hall_evt,
  hst_out_if.source  result
);

  // Input register.
  logic               in_full;
  logic [2:0]         code_r;
  logic [15:0]        raw_r;

  // Tracker state.
  logic [2:0]         prev_code;
  logic [2:0]         prev_sector;
  logic [31:0]        step_count;

  // Result register.
  logic               res_valid;

  logic               advance;
  logic               fire;
  logic [2:0]         sector;
  logic [15:0]        angle;
  logic               restart;
  logic               forward;
  logic [31:0]        count_next;
  logic [15:0]        angle_moved;
  logic [15:0]        angle_next;
  logic               force_next;
  calib_req_t         creq;
  calib_rsp_t         crsp;

  // The stage moves when the result register is empty or being drained.
  assign advance        = !res_valid || result.ready;
  assign fire           = in_full && advance;
  assign hall_evt.ready = !in_full || advance;
  assign result.valid   = res_valid;

  // Decode of the latched event against the previous one.
  always_comb begin
    sector      = sector_of(code_r);
    angle       = angle_of(code_r);
    restart     = (prev_code == 3'd0);
    forward     = !restart && (sector == next_sector(prev_sector));
    angle_moved = forward ? 16'(angle - ANGLE_STEP) : 16'(angle + ANGLE_STEP);
    if (restart) begin
      count_next = '0;
    end else if (forward) begin
      count_next = step_count + 32'd1;
    end else begin
      count_next = step_count - 32'd1;
    end
    force_next = restart || crsp.force_en;
    if (restart) begin
      angle_next = angle;
    end else if (crsp.force_en) begin
      angle_next = angle_moved;
    end else begin
      angle_next = '0;
    end
  end

  assign creq.step    = fire && !restart;
  assign creq.forward = forward;
  assign creq.sector  = sector;
  assign creq.raw     = raw_r;

  hst_calib u_calib (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  // Input register: loads on an accepted beat, empties when the stage fires.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (hall_evt.valid && hall_evt.ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
    if (hall_evt.valid && hall_evt.ready) begin
      code_r <= hall_evt.hall_code;
      raw_r  <= hall_evt.encoder_raw;
    end
  end

  // Tracker state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_code   <= '0;
      prev_sector <= '0;
      step_count  <= '0;
      res_valid   <= 1'b0;
    end else if (fire) begin
      prev_code   <= code_r;
      prev_sector <= sector;
      step_count  <= count_next;
      res_valid   <= 1'b1;
    end else if (result.ready) begin
      res_valid   <= 1'b0;
    end
    if (fire) begin
      result.position_count  <= signed'(count_next);
      result.force_angle     <= angle_next;
      result.force_valid     <= force_next;
      result.encoder_restart <= restart;
      result.moved_forward   <= forward;
      result.calib_done      <= crsp.done;
      result.calib_offset    <= signed'(crsp.offset);
      result.hall_code_out   <= code_r;
    end
  end

  // Result consistency across fields.
  `ASSERT_CLK(a_restart_clears, res_valid && result.encoder_restart |-> (result.position_count == 32'sd0) && !result.moved_forward && result.force_valid, "restart result inconsistent")
  `ASSERT_CLK(a_done_forces, res_valid && result.calib_done |-> result.force_valid && !result.encoder_restart, "calibration done without force")
  `ASSERT_CLK(a_count_tracks, fire && !restart |=> (step_count == $past(step_count) + 32'd1) || (step_count == $past(step_count) - 32'd1), "count moved by more than one")

endmodule

// ===== tb/hall_sector_tracker_with_encoder_calib_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hall_sector_tracker_with_encoder_calib_tb
// Drives Hall edge events into the tracker and checks every result beat
// against an independent prediction of the step count, the forced encoder
// angle and the border calibration. The stimulus starts with a short directed
// part and then moves to random forward and backward rotations mixed with
// invalid codes. Both channels idle at random.
// ----------------------------------------------------------------------------
module hall_sector_tracker_with_encoder_calib_tb
  import hst_pkg::*;
();

  // Hall codes that name no sector.
  localparam logic [2:0] HALL_NONE = 3'd0;
  localparam logic [2:0] HALL_ALL  = 3'd7;

  localparam int EVENT_TOTAL = 850;
  localparam int TAIL_EVENTS = 70;
  localparam int DRAIN_AT    = 400;
  localparam int LONG_HOLD   = 70;
  localparam int HOLD_AT     = 150;

  // Sector and sector angle by Hall code.
  localparam logic [2:0]  SECTOR_BY_CODE [8] = '{3'd0, 3'd4, 3'd2, 3'd3, 3'd0, 3'd5, 3'd1, 3'd0};
  localparam logic [15:0] ANGLE_BY_CODE  [8] = '{16'd0, 16'd49152, 16'd27307, 16'd38229,
                                                 16'd5461, 16'd60075, 16'd16384, 16'd0};
  // Hall code of each sector, and nominal encoder reading at each border.
  localparam logic [2:0]  CODE_BY_SECTOR [6] = '{3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5};
  localparam logic [15:0] BORDER_NOMINAL [6] = '{16'd0, 16'd10923, 16'd21845,
                                                 16'd32768, 16'd43691, 16'd54613};

  typedef enum logic [1:0] {
    CAL_ALIGN   = 2'd0,
    CAL_BORDERS = 2'd1,
    CAL_FINISHED = 2'd2
  } cal_phase_t;

  typedef struct packed {
    logic signed [31:0] position_count;
    logic [15:0]        force_angle;
    logic               force_valid;
    logic               encoder_restart;
    logic               moved_forward;
    logic               calib_done;
    logic signed [15:0] calib_offset;
    logic [2:0]         hall_code;
  } tracker_result_t;

  // Tracks the sector state and border samples and holds the results due.
  class tracker_scoreboard;
    tracker_result_t due_q[$];
    int unsigned     mismatches;
    logic [2:0]      last_code;
    logic [2:0]      last_sector;
    logic [31:0]     steps;
    cal_phase_t      phase;
    logic [15:0]     border_raw [6];
    logic [5:0]      border_seen;

    function new();
      last_code   = HALL_NONE;
      last_sector = 3'd0;
      steps       = '0;
      phase       = CAL_ALIGN;
      border_seen = '0;
      mismatches  = 0;
      foreach (border_raw[i]) border_raw[i] = '0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Predict the result of one accepted event and update the tracked state.
    function void note_event(input logic [2:0] code, input logic [15:0] raw);
      tracker_result_t r;
      logic [2:0]  sector;
      logic [15:0] angle;
      logic        fwd;
      int          border;
      int          err_sum;
      r      = '0;
      sector = SECTOR_BY_CODE[code];
      angle  = ANGLE_BY_CODE[code];
      r.hall_code = code;
      if (last_code == HALL_NONE) begin
        // Previous code was zero: the encoder restarts at the plain table angle.
        steps             = '0;
        r.encoder_restart = 1'b1;
        r.force_valid     = 1'b1;
        r.force_angle     = angle;
      end else begin
        fwd = ((int'(sector) + 6 - int'(last_sector)) % 6) == 1;
        if (fwd) begin
          steps = steps + 32'd1;
          angle = angle - ANGLE_STEP;
          r.moved_forward = 1'b1;
        end else begin
          steps = steps - 32'd1;
          angle = angle + ANGLE_STEP;
        end
        if (phase == CAL_ALIGN) begin
          r.force_valid = 1'b1;
          r.force_angle = angle;
          phase         = CAL_BORDERS;
        end else if (phase == CAL_BORDERS) begin
          r.force_valid = 1'b1;
          r.force_angle = angle;
          border = fwd ? int'(sector) : (int'(sector) + 1) % 6;
          border_raw[border] = raw;
          border_seen = border_seen | 6'(1 << border);
          if (border_seen == SEEN_ALL) begin
            // All borders known: emit the negated mean border error.
            phase       = CAL_FINISHED;
            r.calib_done = 1'b1;
            err_sum = 0;
            for (int i = 0; i < 6; i++) begin
              err_sum += int'($signed(16'(border_raw[i] - BORDER_NOMINAL[i])));
            end
            err_sum = err_sum / 6;
            r.calib_offset = 16'(-err_sum);
          end
        end
      end
      r.position_count = steps;
      last_sector = sector;
      last_code   = code;
      due_q.push_back(r);
    endfunction

    function void check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(input tracker_result_t got);
      tracker_result_t want;
      if (due_q.size() == 0) begin
        $error("result beat with nothing expected, position_count %0d", got.position_count);
        mismatches++;
        return;
      end
      want = due_q.pop_front();
      check_field("position_count", want.position_count, got.position_count);
      check_field("force_angle", {16'd0, want.force_angle}, {16'd0, got.force_angle});
      check_field("force_valid", {31'd0, want.force_valid}, {31'd0, got.force_valid});
      check_field("encoder_restart", {31'd0, want.encoder_restart},
                  {31'd0, got.encoder_restart});
      check_field("moved_forward", {31'd0, want.moved_forward}, {31'd0, got.moved_forward});
      check_field("calib_done", {31'd0, want.calib_done}, {31'd0, got.calib_done});
      check_field("calib_offset", want.calib_offset, got.calib_offset);
      check_field("hall_code_out", {29'd0, want.hall_code}, {29'd0, got.hall_code});
    endfunction
  endclass

  logic clk;
  logic rst;

  hst_in_if  hall_evt_if();
  hst_out_if result_if();

  hall_sector_tracker_with_encoder_calib u_top (
    .clk      (clk),
    .rst      (rst),
    .hall_evt (hall_evt_if),
    .result   (result_if)
  );

  tracker_scoreboard sb;
  int unsigned       events_sent;
  int unsigned       results_seen;
  logic              tail_phase;
  logic              gaps_on;

  // Clock.
  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("hall_sector_tracker_with_encoder_calib_tb failed");
    $finish;
  end

  // Hold the event channel low for a number of cycles.
  task automatic idle_events(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      hall_evt_if.valid = 1'b0;
    end
  endtask

  // Offer one event beat and wait until the block takes it.
  task automatic send_event(input logic [2:0] code, input logic [15:0] raw);
    if (gaps_on && !tail_phase && $urandom_range(0, 4) == 0) begin
      idle_events($urandom_range(1, 14));
    end
    @(negedge clk);
    hall_evt_if.valid       = 1'b1;
    hall_evt_if.hall_code   = code;
    hall_evt_if.encoder_raw = raw;
    do begin
      @(posedge clk);
    end while (!hall_evt_if.ready);
    sb.note_event(code, raw);
    events_sent++;
    if (events_sent >= EVENT_TOTAL - TAIL_EVENTS) begin
      tail_phase = 1'b1;
    end
  endtask

  // Stop offering until every predicted result has come out.
  task automatic drain_results();
    @(negedge clk);
    hall_evt_if.valid = 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Event source: directed part, then random rotations.
  initial begin
    int   cur_sector;
    int   run_len;
    int   kind;
    logic drained;
    logic [2:0] code;
    sb           = new();
    events_sent  = 0;
    tail_phase   = 1'b0;
    gaps_on      = 1'b0;
    drained      = 1'b0;
    rst          = 1'b1;
    hall_evt_if.valid       = 1'b0;
    hall_evt_if.hall_code   = HALL_NONE;
    hall_evt_if.encoder_raw = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Invalid codes first, then a restart from code zero.
    send_event(HALL_ALL, 16'h0000);
    send_event(HALL_NONE, 16'hFFFF);
    send_event(CODE_BY_SECTOR[0], 16'h0000);
    // Backward steps and a stay in sector zero while borders are collected.
    // The first two land on borders zero and five at the negative extreme.
    send_event(CODE_BY_SECTOR[5], 16'h8000);
    send_event(CODE_BY_SECTOR[4], 16'h5555);
    send_event(HALL_ALL, 16'h8000);
    send_event(CODE_BY_SECTOR[0], 16'h7FFF);
    // Forward sweep with every border error at the negative extreme, so the
    // negated mean wraps from +32768 to -32768 when calibration finishes.
    for (int s = 1; s < 6; s++) begin
      send_event(CODE_BY_SECTOR[s], BORDER_NOMINAL[s] ^ 16'h8000);
    end
    send_event(CODE_BY_SECTOR[0], BORDER_NOMINAL[0] ^ 16'h8000);
    // After calibration the encoder is no longer forced.
    send_event(CODE_BY_SECTOR[1], 16'h5555);
    send_event(CODE_BY_SECTOR[0], 16'hAAAA);
    send_event(HALL_NONE, 16'h0001);
    send_event(CODE_BY_SECTOR[3], 16'hFFFE);
    send_event(HALL_NONE, 16'h8001);
    send_event(HALL_NONE, 16'h7FFE);
    cur_sector = 0;

    // Random part: mostly clean rotations, some invalid and arbitrary codes.
    while (events_sent < EVENT_TOTAL) begin
      kind    = $urandom_range(0, 9);
      run_len = $urandom_range(1, 12);
      gaps_on = ($urandom_range(0, 2) != 0);
      if (kind <= 5) begin
        repeat (run_len) begin
          cur_sector = (cur_sector + 1) % 6;
          send_event(CODE_BY_SECTOR[cur_sector], 16'($urandom_range(0, 65535)));
        end
      end else if (kind <= 7) begin
        repeat (run_len) begin
          cur_sector = (cur_sector + 5) % 6;
          send_event(CODE_BY_SECTOR[cur_sector], 16'($urandom_range(0, 65535)));
        end
      end else if (kind == 8) begin
        code = $urandom_range(0, 1) ? HALL_ALL : HALL_NONE;
        send_event(code, 16'($urandom_range(0, 65535)));
        cur_sector = 0;
      end else begin
        code = 3'($urandom_range(0, 7));
        send_event(code, 16'($urandom_range(0, 65535)));
        cur_sector = int'(SECTOR_BY_CODE[code]);
      end
      if (!drained && events_sent >= DRAIN_AT) begin
        drain_results();
        drained = 1'b1;
      end
    end

    // Wind down: wait for the last results, let the clock run on, then report.
    @(negedge clk);
    hall_evt_if.valid = 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("hall_sector_tracker_with_encoder_calib_tb passed");
    end else begin
      $display("hall_sector_tracker_with_encoder_calib_tb failed");
    end
    $finish;
  end

  // Result sink: random stalls, one long hold-off, every beat checked.
  initial begin
    int   stall_left;
    logic held;
    tracker_result_t got;
    stall_left     = 0;
    held           = 1'b0;
    results_seen   = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_if.ready = 1'b0;
      end else begin
        if (!held && results_seen >= HOLD_AT) begin
          stall_left = LONG_HOLD;
          held       = 1'b1;
        end else if (stall_left == 0 && !tail_phase && $urandom_range(0, 6) == 0) begin
          stall_left = $urandom_range(1, 14);
        end
        if (stall_left > 0) begin
          result_if.ready = 1'b0;
          stall_left--;
        end else begin
          result_if.ready = 1'b1;
        end
      end
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        got.position_count  = result_if.position_count;
        got.force_angle     = result_if.force_angle;
        got.force_valid     = result_if.force_valid;
        got.encoder_restart = result_if.encoder_restart;
        got.moved_forward   = result_if.moved_forward;
        got.calib_done      = result_if.calib_done;
        got.calib_offset    = result_if.calib_offset;
        got.hall_code       = result_if.hall_code_out;
        sb.check_result(got);
        results_seen++;
      end
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hst_pkg.sv
rtl/hst_if.sv
rtl/hst_calib.sv
rtl/hall_sector_tracker_with_encoder_calib.sv
tb/hall_sector_tracker_with_encoder_calib_tb.sv
